>>> sv/wsfu_pkg.sv
`default_nettype none

package wsfu_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int LEN_W    = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = 3;
    localparam int IDX_W    = 2;

    localparam logic [6:0]       LEN7_EXT16 = 7'd126;
    localparam logic [6:0]       LEN7_EXT64 = 7'd127;
    localparam logic [CNT_W-1:0] EXT16_BYTES = 3'd2;
    localparam logic [CNT_W-1:0] EXT64_BYTES = 3'd0;
    localparam logic [CNT_W-1:0] KEY_LAST    = 3'd3;

endpackage

`default_nettype wire

>>> sv/websocket_frame_unmasker.sv
`default_nettype none

// Each input byte is captured in the input register; a payload byte then passes to the
// output register, where payload_byte is held valid for the output transfer.
// Throughput: one byte per cycle; the input register feeds the header/unmask logic
// and the output register, and a stalled output holds the input register only while
// it carries a payload byte. Header, length and key bytes produce no output transfer.
// Reset: rst_n asynchronous, active low; returns to waiting for the first header byte.
module websocket_frame_unmasker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] byte_in,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      payload_byte,
    output logic [3:0]      frame_opcode,
    output logic            last_byte
);
    import wsfu_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [OPCODE_W-1:0] opcode_reg, opcode_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LEN_W-1:0]    length_reg, length_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    logic                s0_valid_reg;
    logic [BYTE_W-1:0]   s0_byte_reg;

    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic [OPCODE_W-1:0] out_opcode_reg;
    logic                out_last_reg;

    logic                produce;
    logic                out_free;
    logic                advance;
    logic [6:0]          len7;
    logic [CNT_W-1:0]    count_dec;
    logic [BYTE_W-1:0]   key_byte;
    logic                is_last;

    assign produce  = s0_valid_reg && (phase_reg == PH_DATA);
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s0_valid_reg && (!produce || out_free);
    assign in_stall = s0_valid_reg && !advance;

    assign len7      = s0_byte_reg[6:0];
    assign count_dec = count_reg - 3'd1;
    assign is_last   = (length_reg == {{(LEN_W-1){1'b0}}, 1'b1});

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64)
                        phase_next = PH_EXT;
                    else
                        phase_next = PH_MASK;
                end
                PH_EXT:
                begin
                    if (count_dec == '0)
                        phase_next = PH_MASK;
                end
                PH_MASK:
                begin
                    if (count_reg == KEY_LAST)
                        phase_next = (length_reg == '0) ? PH_HDR0 : PH_DATA;
                end
                PH_DATA:
                begin
                    if (is_last)
                        phase_next = PH_HDR0;
                end
                default: phase_next = PH_HDR1;
            endcase
        end
    end

    // datapath
    always_comb
    begin
        opcode_next = opcode_reg;
        count_next  = count_reg;
        length_next = length_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        if (advance)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    if (len7 == LEN7_EXT16)
                    begin
                        length_next = '0;
                        count_next  = EXT16_BYTES;
                    end
                    else if (len7 == LEN7_EXT64)
                    begin
                        length_next = '0;
                        count_next  = EXT64_BYTES;
                    end
                    else
                    begin
                        length_next = {{(LEN_W-7){1'b0}}, len7};
                        count_next  = '0;
                        key_next    = '0;
                    end
                end
                PH_EXT:
                begin
                    length_next = {length_reg[LEN_W-BYTE_W-1:0], s0_byte_reg};
                    count_next  = count_dec;
                    if (count_dec == '0)
                        key_next = '0;
                end
                PH_MASK:
                begin
                    key_next = {key_reg[KEY_W-BYTE_W-1:0], s0_byte_reg};
                    if (count_reg == KEY_LAST)
                    begin
                        count_next = '0;
                        idx_next   = '0;
                    end
                    else
                        count_next = count_reg + 3'd1;
                end
                PH_DATA:
                begin
                    length_next = length_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                    idx_next    = idx_reg + 2'd1;
                end
                default: opcode_next = s0_byte_reg[OPCODE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            count_reg  <= '0;
            length_reg <= '0;
            key_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (!in_stall)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s0_byte_reg <= byte_in;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && produce)
            out_valid_reg <= 1'b1;
        else if (out_free)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_byte_reg   <= s0_byte_reg ^ key_byte;
            out_opcode_reg <= opcode_reg;
            out_last_reg   <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = out_byte_reg;
    assign frame_opcode = out_opcode_reg;
    assign last_byte    = out_last_reg;

`ifndef SYNTHESIS
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && produce && is_last) |=> (phase_reg == PH_HDR0))
        else $error("last payload byte did not end the frame");

    a_hdr0_to_hdr1: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_HDR0) |=> (phase_reg == PH_HDR1))
        else $error("first header byte did not advance to length byte");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s0_valid_reg && out_valid_reg && produce))
        else $error("input stalled without a blocked payload byte");

    a_mask_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MASK) |-> (count_reg <= KEY_LAST))
        else $error("mask key count out of range");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (length_reg != '0))
        else $error("payload phase with zero bytes remaining");
`endif

endmodule

`default_nettype wire
